>>> rtl/prmt_pkg.sv
`timescale 1ns / 1ps
package prmt_pkg;
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_RESPONSE = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_MATCHED = 3'd0,
		KIND_DEFAULT = 3'd1,
		KIND_EXPIRED = 3'd2,
		KIND_INSERTED = 3'd3,
		KIND_FULL = 3'd4,
		KIND_DONE = 3'd5
	} kind_t;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_TOKEN_LEN = 2'd1;
	localparam logic [1:0] REG_DEFAULT = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [15:0] msg_id;
		logic [63:0] token;
		logic [7:0]  handler;
		logic [31:0] stamp;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic        clear_all;
		logic        load;
		logic        do_match;
		logic        do_expire;
		logic [15:0] msg_id;
		logic [63:0] token_mask;
		logic [63:0] token;
		logic        token_ok;
		logic [31:0] now;
		logic [31:0] timeout;
	} cell_ctl_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] nbytes,
		input logic [3:0] max_bytes);
		logic [3:0] n;
		logic [63:0] m;
		n = (nbytes > max_bytes) ? max_bytes : nbytes;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) m[b*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction
endpackage

>>> rtl/prmt_if.sv
`timescale 1ns / 1ps
interface prmt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] msg_id;
	logic [63:0] token;
	logic [3:0]  token_len;
	logic [7:0]  handler_id;
	logic [31:0] now_ms;
	modport source(output valid, func, msg_id, token, token_len, handler_id, now_ms,
		input ready);
	modport sink(input valid, func, msg_id, token, token_len, handler_id, now_ms,
		output ready);
endinterface

interface prmt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] handler_id_res;
	logic       last;
	modport source(output valid, kind, handler_id_res, last, input ready);
	modport sink(input valid, kind, handler_id_res, last, output ready);
endinterface

>>> rtl/pending_request_match_table_core.sv
`timescale 1ns / 1ps
// Flow: an item is taken only while idle; every result beat is registered and
// the pass waits until it is taken, and the expiry pass ends on a step that finds
// nothing to remove. One item is handled at a time: the next is taken only after
// the block is through with the item and its result beats have been taken.
// Reset: arst_n clears all entry valid bits and returns the state, count, output
// and configuration registers to their defaults.
module pending_request_match_table_core #(
	parameter int TABLE_DEPTH = 16,
	parameter int TOKEN_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	prmt_in_if.sink     in_ch,
	prmt_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import prmt_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [3:0] TokBytes = 4'(TOKEN_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MATCH, ST_EXPIRE, ST_TAIL, ST_OUT
	} state_t;

	// Configuration registers.
	logic [31:0] timeout_q;
	logic [3:0]  tok_len_cfg_q;
	logic [7:0]  def_handler_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd5000;
			tok_len_cfg_q <= 4'd8;
			def_handler_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_wdata;
				REG_TOKEN_LEN: tok_len_cfg_q <= cfg_wdata[3:0];
				REG_DEFAULT: def_handler_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// The captured item.
	func_t       func_q;
	logic [15:0] msg_id_q;
	logic [63:0] token_q;
	logic [3:0]  token_len_q;
	logic [7:0]  handler_q;
	logic [31:0] now_q;

	state_t      state_q;
	state_t      state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [7:0]  out_handler_q;
	logic        out_last_q;
	logic        beat_load;
	kind_t       beat_kind;
	logic [7:0]  beat_handler;
	logic        beat_last;

	// The chain of cells.
	cell_ctl_t ctl;
	entry_t    entries [TABLE_DEPTH];
	logic [TABLE_DEPTH:0] kill;
	logic      any_kill;
	logic [7:0] kill_handler;
	entry_t    new_entry;
	logic [TABLE_DEPTH-1:0] load_here;
	logic [TABLE_DEPTH-1:0] expiring;
	logic [TABLE_DEPTH-1:0] killed;

	assign kill[0] = 1'b0;
	assign any_kill = kill[TABLE_DEPTH];

	always_comb begin
		new_entry.valid = 1'b1;
		new_entry.msg_id = msg_id_q;
		new_entry.token = token_q & byte_mask(TokBytes, TokBytes);
		new_entry.handler = handler_q;
		new_entry.stamp = now_q;
	end

	always_comb begin
		ctl = '0;
		ctl.msg_id = msg_id_q;
		ctl.token = token_q;
		ctl.token_mask = (tok_len_cfg_q == 4'd0) ? 64'd0 :
			byte_mask(token_len_q, TokBytes);
		ctl.token_ok = (tok_len_cfg_q == 4'd0) || (tok_len_cfg_q == token_len_q);
		ctl.now = now_q;
		ctl.timeout = timeout_q;
		ctl.do_match = (state_q == ST_MATCH) && !out_valid_q;
		ctl.do_expire = (state_q == ST_EXPIRE) && !out_valid_q;
		ctl.load = (state_q == ST_TAIL) && !out_valid_q && (func_q == FUNC_INSERT) &&
			(count_q < CW'(TABLE_DEPTH));
		ctl.clear_all = 1'b0;
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			entry_t nxt;
			logic k;
			if (g == TABLE_DEPTH - 1) begin : g_end
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = entries[g+1];
			end
			assign load_here[g] = ctl.load && (count_q == CW'(g));
			prmt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .load_here(load_here[g]),
				.new_entry(new_entry), .next_entry(nxt),
				.kill_before(kill[g]), .kill_here(k), .entry(entries[g])
			);
			assign kill[g+1] = kill[g] | k;
		end
	endgenerate

	// Which cell is removed this cycle, its handler, and which entries are
	// past the timeout. A response beat is the last one of its item when no
	// entry other than the one being removed is still waiting to expire.
	always_comb begin
		kill_handler = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			killed[i] = kill[i+1] && !kill[i];
			expiring[i] = entries[i].valid && ((now_q - entries[i].stamp) > timeout_q);
			if (killed[i]) kill_handler = entries[i].handler;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = out_kind_q;
	assign out_ch.handler_id_res = out_handler_q;
	assign out_ch.last = out_last_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_q <= func_t'(in_ch.func);
			msg_id_q <= in_ch.msg_id;
			token_q <= in_ch.token;
			token_len_q <= in_ch.token_len;
			handler_q <= in_ch.handler_id;
			now_q <= in_ch.now_ms;
		end
	end

	// The sequencer: one removal, with its result beat, at a time. A beat is held
	// in the output register; the chain waits while it is not taken.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		beat_load = 1'b0;
		beat_kind = KIND_DONE;
		beat_handler = '0;
		beat_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					unique case (func_t'(in_ch.func))
						FUNC_INSERT, FUNC_TICK: state_d = ST_EXPIRE;
						FUNC_RESPONSE: state_d = ST_MATCH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MATCH: begin
				if (!out_valid_q) begin
					beat_load = 1'b1;
					beat_last = ((expiring & ~killed) == '0);
					if (any_kill) begin
						beat_kind = KIND_MATCHED;
						beat_handler = kill_handler;
						count_d = count_q - 1'b1;
					end else begin
						beat_kind = KIND_DEFAULT;
						beat_handler = def_handler_q;
					end
					state_d = ST_EXPIRE;
				end
			end
			ST_EXPIRE: begin
				if (!out_valid_q) begin
					if (any_kill) begin
						count_d = count_q - 1'b1;
						beat_load = 1'b1;
						beat_kind = KIND_EXPIRED;
						beat_handler = kill_handler;
						beat_last = (func_q == FUNC_RESPONSE) &&
							((expiring & ~killed) == '0);
					end else begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (!out_valid_q) begin
					if (func_q == FUNC_RESPONSE) begin
						// The previous beat closed the item.
						state_d = ST_IDLE;
					end else begin
						beat_load = 1'b1;
						beat_last = 1'b1;
						if (func_q == FUNC_TICK) begin
							beat_kind = KIND_DONE;
							beat_handler = '0;
						end else if (ctl.load) begin
							beat_kind = KIND_INSERTED;
							beat_handler = handler_q;
							count_d = count_q + 1'b1;
						end else begin
							beat_kind = KIND_FULL;
							beat_handler = handler_q;
						end
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= '0;
			out_handler_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (beat_load) begin
				out_valid_q <= 1'b1;
				out_kind_q <= beat_kind;
				out_handler_q <= beat_handler;
				out_last_q <= beat_last;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(kill ^ (kill << 1)) <= 2)
		else $error("more than one cell removed per cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !out_valid_q)
		else $error("idle with a beat pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !any_kill)
		else $error("load during removal");
endmodule

>>> rtl/prmt_cell.sv
`timescale 1ns / 1ps
// One table slot. The chain shifts toward slot 0: a cell whose slot or any
// slot in front of it is removed takes its successor's entry.
module prmt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  prmt_pkg::cell_ctl_t ctl,
	input  logic              load_here,
	input  prmt_pkg::entry_t  new_entry,
	input  prmt_pkg::entry_t  next_entry,
	input  logic              kill_before,
	output logic              kill_here,
	output prmt_pkg::entry_t  entry
);
	import prmt_pkg::*;

	logic        valid_q;
	logic [15:0] msg_id_q;
	logic [63:0] token_q;
	logic [7:0]  handler_q;
	logic [31:0] stamp_q;
	logic hit;
	logic shift;

	always_comb begin
		hit = 1'b0;
		if (valid_q) begin
			if (ctl.do_match)
				hit = (msg_id_q == ctl.msg_id) && ctl.token_ok &&
					(((token_q ^ ctl.token) & ctl.token_mask) == '0);
			else if (ctl.do_expire)
				hit = (ctl.now - stamp_q) > ctl.timeout;
		end
	end

	// Only the first hit in the chain is removed per cycle.
	assign kill_here = hit && !kill_before;
	assign shift = kill_here || kill_before;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear_all) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_entry.valid;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			msg_id_q <= next_entry.msg_id;
			token_q <= next_entry.token;
			handler_q <= next_entry.handler;
			stamp_q <= next_entry.stamp;
		end else if (load_here) begin
			msg_id_q <= new_entry.msg_id;
			token_q <= new_entry.token;
			handler_q <= new_entry.handler;
			stamp_q <= new_entry.stamp;
		end
	end

	assign entry = {valid_q, msg_id_q, token_q, handler_q, stamp_q};
endmodule

>>> sim/prmt_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL file rtl/prmt_if.sv; this file only
// holds the result record shared by the testbench scoreboard.
package prmt_tb_pkg;
	import prmt_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [7:0] handler;
		logic       last;
	} result_beat_t;
endpackage

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import prmt_pkg::*;
	import prmt_tb_pkg::*;

	localparam int DEPTH = 16;
	localparam int TOKEN_BYTES = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam longint CYCLE_LIMIT = 400000;

	// The scoreboard mirrors the table contents and holds every result beat
	// that the block still owes, oldest first.
	class table_scoreboard;
		logic [31:0] timeout_ms;
		logic [3:0] token_len_cfg;
		logic [7:0] default_handler;
		logic [15:0] ent_msg_id[$];
		logic [63:0] ent_token[$];
		logic [7:0] ent_handler[$];
		logic [31:0] ent_time[$];
		result_beat_t owed[$];
		int errors;
		int beats_checked;

		function void reset_state();
			timeout_ms = 32'd5000;
			token_len_cfg = 4'd8;
			default_handler = 8'd0;
			ent_msg_id.delete();
			ent_token.delete();
			ent_handler.delete();
			ent_time.delete();
			owed.delete();
			errors = 0;
			beats_checked = 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [31:0] data);
			if (idx == REG_TIMEOUT) timeout_ms = data;
			else if (idx == REG_TOKEN_LEN) token_len_cfg = data[3:0];
			else if (idx == REG_DEFAULT) default_handler = data[7:0];
		endfunction

		function void push_beat(kind_t k, logic [7:0] h, ref result_beat_t beats[$]);
			result_beat_t b;
			b.kind = k;
			b.handler = h;
			b.last = 1'b0;
			beats.push_back(b);
		endfunction

		function void drop_entry(int i);
			ent_msg_id.delete(i);
			ent_token.delete(i);
			ent_handler.delete(i);
			ent_time.delete(i);
		endfunction

		// Every entry whose wrapped age exceeds the timeout leaves the table,
		// oldest first, one beat per entry.
		function void expire_pass(logic [31:0] now, ref result_beat_t beats[$]);
			int i;
			logic [31:0] age;
			i = 0;
			while (i < ent_time.size()) begin
				age = now - ent_time[i];
				if (age > timeout_ms) begin
					push_beat(KIND_EXPIRED, ent_handler[i], beats);
					drop_entry(i);
				end else begin
					i++;
				end
			end
		endfunction

		function logic [63:0] low_bytes(logic [3:0] n);
			logic [63:0] m;
			m = '0;
			for (int b = 0; b < TOKEN_BYTES; b++)
				if (b < n) m[b*8 +: 8] = 8'hFF;
			return m;
		endfunction

		function void note_request(logic [1:0] func, logic [15:0] msg_id,
			logic [63:0] token, logic [3:0] tlen, logic [7:0] handler,
			logic [31:0] now);
			result_beat_t beats[$];
			bit found;
			bit hit;
			found = 0;
			case (func)
				FUNC_INSERT: begin
					expire_pass(now, beats);
					if (ent_time.size() >= DEPTH) begin
						push_beat(KIND_FULL, handler, beats);
					end else begin
						ent_msg_id.push_back(msg_id);
						ent_token.push_back(token);
						ent_handler.push_back(handler);
						ent_time.push_back(now);
						push_beat(KIND_INSERTED, handler, beats);
					end
				end
				FUNC_RESPONSE: begin
					for (int i = 0; i < ent_time.size() && !found; i++) begin
						hit = ent_msg_id[i] == msg_id;
						if (hit && token_len_cfg != 0)
							hit = (token_len_cfg == tlen) &&
								(((ent_token[i] ^ token) & low_bytes(tlen)) == 0);
						if (hit) begin
							push_beat(KIND_MATCHED, ent_handler[i], beats);
							drop_entry(i);
							found = 1;
						end
					end
					if (!found) push_beat(KIND_DEFAULT, default_handler, beats);
					expire_pass(now, beats);
				end
				FUNC_TICK: begin
					expire_pass(now, beats);
					push_beat(KIND_DONE, 8'd0, beats);
				end
				default: ;
			endcase
			if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
			foreach (beats[i]) owed.push_back(beats[i]);
		endfunction

		function void check_beat(logic [2:0] kind, logic [7:0] handler, logic last);
			result_beat_t e;
			beats_checked++;
			if (owed.size() == 0) begin
				$display("%0t: unexpected beat kind %0d handler %0d last %0b",
					$time, kind, handler, last);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (kind != e.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
				errors++;
			end
			if (handler != e.handler) begin
				$display("%0t: handler expected %0d actual %0d", $time, e.handler,
					handler);
				errors++;
			end
			if (last != e.last) begin
				$display("%0t: last expected %0b actual %0b", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_wdata;

	prmt_in_if in_ch();
	prmt_out_if out_ch();

	pending_request_match_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	table_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles;
	int item_count;

	// Model time: the stimulus advances a millisecond clock of its own and
	// keeps a handful of recent ids so that responses actually hit.
	logic [31:0] clock_ms;
	logic [15:0] recent_id[$];
	logic [63:0] recent_tok[$];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random back-pressure, every accepted beat is checked at the
	// edge where it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_beat(out_ch.kind, out_ch.handler_id_res, out_ch.last);
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sends one beat: an optional idle gap, then valid held until accepted.
	// The sampling of ready happens at the edge, so the beat is noted in the
	// scoreboard exactly when the block takes it. Valid stays high afterwards
	// so that a following item can go out back to back; drain drops it.
	task automatic send_item(logic [1:0] func, logic [15:0] msg_id,
		logic [63:0] token, logic [3:0] tlen, logic [7:0] handler,
		logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.msg_id <= msg_id;
		in_ch.token <= token;
		in_ch.token_len <= tlen;
		in_ch.handler_id <= handler;
		in_ch.now_ms <= now;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(func, msg_id, token, tlen, handler, now);
		item_count++;
	endtask

	// Waits for every owed beat and then lets the block settle; an unused
	// function code produces no beat, so the extra cycles cover it.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_token();
		return {$urandom(), $urandom()};
	endfunction

	// One random item. Mostly inserts and responses that reuse earlier ids
	// and tokens, with ticks, ignored codes and garbage mixed in.
	task automatic random_item();
		int sel;
		int k;
		logic [15:0] id;
		logic [63:0] tok;
		logic [3:0] tlen;
		sel = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(sb.timeout_ms < 64 ? 40 : 900);
		if ($urandom_range(49) == 0) clock_ms = $urandom();
		if (sel < 40) begin
			id = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(7));
			tok = rand_token();
			recent_id.push_back(id);
			recent_tok.push_back(tok);
			if (recent_id.size() > 24) begin
				void'(recent_id.pop_front());
				void'(recent_tok.pop_front());
			end
			send_item(FUNC_INSERT, id, tok, 4'($urandom()), 8'($urandom()), clock_ms);
		end else if (sel < 80) begin
			tlen = ($urandom_range(4) == 0) ? 4'($urandom()) : sb.token_len_cfg;
			if (recent_id.size() > 0 && $urandom_range(4) != 0) begin
				k = $urandom_range(recent_id.size() - 1);
				id = recent_id[k];
				tok = recent_tok[k];
				if ($urandom_range(5) == 0) tok[$urandom_range(63)] ^= 1'b1;
			end else begin
				id = 16'($urandom());
				tok = rand_token();
			end
			send_item(FUNC_RESPONSE, id, tok, tlen, 8'($urandom()), clock_ms);
		end else if (sel < 95) begin
			send_item(FUNC_TICK, 16'($urandom()), rand_token(), 4'($urandom()),
				8'($urandom()), clock_ms);
		end else begin
			send_item(FUNC_NONE, 16'($urandom()), rand_token(), 4'($urandom()),
				8'($urandom()), clock_ms);
		end
	endtask

	task automatic random_phase(int n, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < n; i++) begin
			random_item();
			// Hold-off: let all owed result beats drain once in a while.
			if ($urandom_range(59) == 0) drain();
		end
		drain();
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles = 0;
		item_count = 0;
		clock_ms = 32'd0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_TICK;
		in_ch.msg_id = '0;
		in_ch.token = '0;
		in_ch.token_len = '0;
		in_ch.handler_id = '0;
		in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset settings: fill the table past full,
		// match on id and all eight token bytes, miss on a short token,
		// expire at the exact timeout boundary, then the unused code.
		send_item(FUNC_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'hFF, 32'd0);
		send_item(FUNC_INSERT, 16'h0000, 64'h0, 4'h0, 8'h00, 32'd0);
		for (int i = 0; i < DEPTH; i++)
			send_item(FUNC_INSERT, 16'(i + 1), {32'(i), 32'hA5A5_0000 + i}, 4'd8,
				8'(i + 1), 32'd10);
		send_item(FUNC_RESPONSE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'd0, 32'd20);
		send_item(FUNC_RESPONSE, 16'h0000, 64'h0, 4'd7, 8'd0, 32'd20);
		send_item(FUNC_TICK, 16'h0, 64'h0, 4'd0, 8'd0, 32'd5000);
		send_item(FUNC_TICK, 16'h0, 64'h0, 4'd0, 8'd0, 32'd5011);
		send_item(FUNC_NONE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'hFF,
			32'hFFFF_FFFF);
		drain();

		// Match on id only, a default handler, and a wrap of the time base.
		write_reg(REG_TOKEN_LEN, 32'd0);
		write_reg(REG_DEFAULT, 32'd255);
		write_reg(REG_TIMEOUT, 32'd100);
		send_item(FUNC_INSERT, 16'd7, 64'h1, 4'd1, 8'd33, 32'hFFFF_FFC0);
		send_item(FUNC_RESPONSE, 16'd7, 64'h2, 4'd3, 8'd0, 32'h0000_0010);
		send_item(FUNC_RESPONSE, 16'd7, 64'h2, 4'd3, 8'd0, 32'h0000_0010);
		send_item(FUNC_INSERT, 16'd8, 64'h1, 4'd1, 8'd34, 32'hFFFF_FFF0);
		send_item(FUNC_TICK, 16'd0, 64'h0, 4'd0, 8'd0, 32'h0000_0080);
		drain();

		// Random phases across settings, including both timeout extremes.
		write_reg(REG_TOKEN_LEN, 32'd8);
		write_reg(REG_DEFAULT, 32'd0);
		write_reg(REG_TIMEOUT, 32'd5000);
		random_phase(RANDOM_ITEMS / 5, 10, 54);
		write_reg(REG_TOKEN_LEN, 32'd3);
		write_reg(REG_DEFAULT, 32'd17);
		write_reg(REG_TIMEOUT, 32'd0);
		random_phase(RANDOM_ITEMS / 5, 54, 10);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_TOKEN_LEN, 32'd1);
		random_phase(RANDOM_ITEMS / 5, 54, 10);
		write_reg(REG_TIMEOUT, 32'd1500);
		write_reg(REG_TOKEN_LEN, 32'd0);
		write_reg(REG_DEFAULT, 32'd1);
		random_phase(RANDOM_ITEMS / 5, 0, 0);
		write_reg(REG_TOKEN_LEN, 32'd15);
		write_reg(REG_TIMEOUT, 32'd3000);
		random_phase(RANDOM_ITEMS / 5, 0, 0);

		$display("Covered %0d request beats and %0d result beats over five settings,",
			item_count, sb.beats_checked);
		$display("including table full, id-only matching and timeout extremes.");
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/prmt_pkg.sv
rtl/prmt_if.sv
rtl/prmt_cell.sv
rtl/pending_request_match_table_core.sv
sim/prmt_tb_if.sv
sim/testbench.sv
